@@ rtl/periodic_packet_stats_sampler_top_assert.svh @@
// Assertion macros for the periodic packet statistics sampler.
`ifndef PERIODIC_PACKET_STATS_SAMPLER_TOP_ASSERT_SVH
`define PERIODIC_PACKET_STATS_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ppss_pkg.sv @@
// Package: widths, codes, item types and defaults of the packet stats sampler.
package ppss_pkg;

    localparam int TS_W       = 63;
    localparam int LEN_W      = 16;
    localparam int TOT_W      = 32;
    localparam int PER_W      = 48;
    localparam int NB_W       = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 63;

    localparam int DEFAULT_FIFO_DEPTH = 256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BOUNDARY = 1'd1;

    // item function codes
    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam logic [PER_W-1:0] PERIOD_RESET   = 48'd1000000;
    localparam logic [NB_W-1:0]  BOUNDARY_RESET = 64'd0;

    typedef struct packed {
        logic             func;
        logic [TS_W-1:0]  timestamp;
        logic [LEN_W-1:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic             sample_lost;
        logic             sample_valid;
        logic [TS_W-1:0]  sample_time;
        logic [TOT_W-1:0] sample_packets;
        logic [TOT_W-1:0] sample_byte_total;
    } t_out_item;

    typedef struct packed {
        logic [TS_W-1:0]  time_ns;
        logic [TOT_W-1:0] packets;
        logic [TOT_W-1:0] bytes;
    } t_sample;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef struct packed {
        logic             done;
        logic [PER_W-1:0] rem;
    } t_div_result;

endpackage

@@ rtl/periodic_packet_stats_sampler_top.sv @@
// Periodic packet stats sampler: packet and read sequencer around a remainder unit and FIFO.
// A packet that crosses no boundary or a read of an empty FIFO goes from evaluation straight
// to done, a read that pops passes the read-data state, a packet crossing within one period
// passes previous-boundary and push, and catch-up first runs the bit-serial remainder unit.
// One item at a time: the next item is taken only after the last result is registered.
// Synchronous active-low reset clears control, totals, boundary, FIFO pointers; period to 1e6.
module periodic_packet_stats_sampler_top
    import ppss_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PREV  = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;
    localparam logic [2:0] ST_RDATA = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;

    logic [PER_W-1:0]  r_period;
    logic [NB_W-1:0]   r_nb;
    logic [TOT_W-1:0]  r_pkt;
    logic [TOT_W-1:0]  r_bytes;

    logic              r_func;
    logic [TS_W-1:0]   r_ts;
    logic [LEN_W-1:0]  r_len;
    logic              r_due;
    logic [TS_W-1:0]   r_diff;
    logic [PER_W-1:0]  r_rem;
    logic [TS_W-1:0]   r_prev;
    t_out_item         r_res;

    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              accept;
    logic              out_free;
    logic              in_period;
    logic              div_start;
    logic [NB_W-1:0]   ts_ext;
    logic [NB_W-1:0]   gap;
    t_fifo_ctrl        fifo_ctrl;
    t_fifo_status      fifo_st;
    t_sample           fifo_wr;
    t_sample           fifo_rd;
    t_div_result       div_res;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign ts_ext   = {1'b0, i_data.timestamp};
    assign gap      = ts_ext - r_nb - NB_W'(1);
    assign in_period = (r_diff < {{(TS_W-PER_W){1'b0}}, r_period});
    assign div_start = (r_state == ST_EVAL) && (r_func == FUNC_PACKET) && r_due && !in_period;

    // FIFO controls
    assign fifo_ctrl.push = (r_state == ST_PUSH) && !fifo_st.full;
    assign fifo_ctrl.pop  = (r_state == ST_EVAL) && (r_func == FUNC_READ) && !fifo_st.empty;
    assign fifo_wr.time_ns = r_prev;
    assign fifo_wr.packets = r_pkt;
    assign fifo_wr.bytes   = r_bytes;

    ppss_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_diff),
        .i_divisor  (r_period),
        .o_result   (div_res)
    );

    ppss_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (fifo_ctrl),
        .i_wr_data (fifo_wr),
        .o_rd_data (fifo_rd),
        .o_status  (fifo_st)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_func == FUNC_READ) begin
                    n_state = fifo_st.empty ? ST_DONE : ST_RDATA;
                end else if (!r_due) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = in_period ? ST_PREV : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) n_state = ST_PREV;
            end
            ST_PREV:  n_state = ST_PUSH;
            ST_PUSH:  n_state = ST_DONE;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state, configuration, totals and boundary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_period <= PERIOD_RESET;
            r_nb     <= BOUNDARY_RESET;
            r_pkt    <= '0;
            r_bytes  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SAMPLE_PERIOD) begin
                    r_period <= (i_cfg_data[PER_W-1:0] == '0) ? PER_W'(1)
                                                             : i_cfg_data[PER_W-1:0];
                end else begin
                    r_nb <= {1'b0, i_cfg_data};
                end
            end
            if (r_state == ST_PUSH) begin
                r_nb <= {1'b0, r_prev} + {{(NB_W-PER_W){1'b0}}, r_period};
            end
            // count the packet once the snapshot decision is made
            if ((r_state == ST_PUSH) ||
                (r_state == ST_EVAL && r_func == FUNC_PACKET && !r_due)) begin
                r_pkt   <= r_pkt + TOT_W'(1);
                r_bytes <= r_bytes + {{(TOT_W-LEN_W){1'b0}}, r_len};
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_data.func;
            r_ts   <= i_data.timestamp;
            r_len  <= i_data.packet_length;
            r_due  <= (r_nb < ts_ext);
            r_diff <= gap[TS_W-1:0];
        end
        unique case (r_state)
            ST_EVAL: begin
                r_res <= '0;
                if (in_period) r_rem <= r_diff[PER_W-1:0];
            end
            ST_DIV: begin
                if (div_res.done) r_rem <= div_res.rem;
            end
            ST_PREV: begin
                // last boundary passed: timestamp - 1 - remainder
                r_prev <= r_ts - TS_W'(1) - {{(TS_W-PER_W){1'b0}}, r_rem};
            end
            ST_PUSH: begin
                // result cleared in ST_EVAL
                r_res.sample_lost <= fifo_st.full;
            end
            ST_RDATA: begin
                r_res.sample_lost       <= 1'b0;
                r_res.sample_valid      <= 1'b1;
                r_res.sample_time       <= fifo_rd.time_ns;
                r_res.sample_packets    <= fifo_rd.packets;
                r_res.sample_byte_total <= fifo_rd.bytes;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`include "periodic_packet_stats_sampler_top_assert.svh"

    `PPSS_ASSERT_NEXT(a_busy_after_accept, accept, o_stall, "block ready right after an accept")
    `PPSS_ASSERT_NOW(a_div_done_in_div, div_res.done, r_state == ST_DIV, "remainder done outside wait")
    `PPSS_ASSERT_NEXT(a_push_fills, fifo_ctrl.push, !fifo_st.empty, "FIFO empty after a push")
    `PPSS_ASSERT_NOW(a_lost_not_valid, o_valid && o_data.sample_lost, !o_data.sample_valid,
                     "result both lost and valid")

endmodule

@@ rtl/ppss_divider.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ppss_divider
    import ppss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TS_W-1:0]   i_dividend,
    input  logic [PER_W-1:0]  i_divisor,
    output t_div_result       o_result
);

    localparam int CNT_W = $clog2(TS_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TS_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TS_W-1:0]  r_dvd;
    logic [PER_W-1:0] r_rem;

    logic [PER_W:0]   trial;
    logic [PER_W:0]   diff;
    logic             ge;

    // shift in the next dividend bit and subtract where it fits
    always_comb begin
        trial = {r_rem, r_dvd[TS_W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TS_W-2:0], 1'b0};
            r_rem <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
        end
    end

    assign o_result.done = r_done;
    assign o_result.rem  = r_rem;

endmodule

@@ rtl/ppss_fifo.sv @@
// Sample FIFO: snapshot memory with pointers, fill count and registered read.
module ppss_fifo
    import ppss_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_fifo_ctrl    i_ctrl,
    input  t_sample       i_wr_data,
    output t_sample       o_rd_data,
    output t_fifo_status  o_status
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    t_sample          r_mem [FIFO_DEPTH];
    t_sample          r_rd_data;
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_ctrl.pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_ctrl.push && !i_ctrl.pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_ctrl.pop && !i_ctrl.push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wptr] <= i_wr_data;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    assign o_rd_data      = r_rd_data;
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

endmodule
